// ===== sv/sidac_pkg.sv =====
// ----------------------------------------------------------------------------
// sidac_pkg
// Shared constants, types and helpers for the signed integer to decimal
// ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package sidac_pkg;

   localparam int VALUE_WIDTH = 32;

   // digits needed for the magnitude of the most negative value
   function automatic int digit_count(input int w);
      logic [64:0] v;
      int          n;
      int          i;
      v = 65'd1 << (w - 1);
      n = 0;
      for (i = 0; i < 21; i++) begin
         if (v != 65'd0) begin
            n++;
            v = v / 65'd10;
         end
      end
      return n;
   endfunction

   localparam int NUM_DIGITS    = digit_count(VALUE_WIDTH);
   localparam int BCD_WIDTH     = 4 * NUM_DIGITS;
   localparam int CNT_WIDTH     = $clog2(VALUE_WIDTH + 1);
   localparam int DIG_IDX_WIDTH = $clog2(NUM_DIGITS);

   localparam logic [7:0] CHAR_MINUS = 8'd45;
   localparam logic [7:0] CHAR_ZERO  = 8'd48;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT
   } state_type;

   typedef struct packed {
      logic                 done;
      logic                 neg;
      logic [BCD_WIDTH-1:0] bcd;
   } conv_result_type;

endpackage

`default_nettype wire

// ===== sv/signed_int_to_decimal_ascii_core.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Converts a signed integer to its decimal ASCII text, one byte per item.
//
// Input channel req_: one signed VALUE_WIDTH-bit value per item.
// Output channel rsp_: one ASCII byte per item, '-' first for negative
// values, then digits most significant first without leading zeros;
// rsp_last_char marks the final byte of each number.
// Conversion runs in a shift-and-add-3 unit, one magnitude bit per cycle.
// The sequencer then passes the bytes through a registered output stage
// onto rsp_, one byte per cycle while the receiver accepts them.
// req_ready drops from acceptance until the converted digits move to the
// character sequencer; the next value converts while the previous text is
// still going out. When the receiver stalls, the output register holds
// its byte and the sequencer waits; conversion of a new value completes
// and then holds until the sequencer frees up.
// Reset (synchronous) empties both stages; no item is in flight after it.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_decimal_ascii_core
   import sidac_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [VALUE_WIDTH-1:0] req_value,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [7:0]                  rsp_char_byte,
   output logic                        rsp_last_char
);

   state_type       state_ff, state_in;
   conv_result_type conv;
   logic            start;
   logic            load;
   logic            emit_busy;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (conv.done && !emit_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      load      = 1'b0;
      unique case (state_ff)
         ST_IDLE:    req_ready = 1'b1;
         ST_CONVERT: load = conv.done && !emit_busy;
         default:    req_ready = 1'b0;
      endcase
   end

   assign start = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   sidac_dabble u_dabble (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .value  (req_value),
      .ack    (load),
      .result (conv)
   );

   sidac_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .load          (load),
      .conv          (conv),
      .busy          (emit_busy),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_byte (rsp_char_byte),
      .rsp_last_char (rsp_last_char)
   );

endmodule

`default_nettype wire

// ===== sv/sidac_dabble.sv =====
// ----------------------------------------------------------------------------
// sidac_dabble
// Iterative binary to BCD unit: one shift-and-add-3 step per cycle over the
// magnitude bits. Holds the result until acknowledged.
// ----------------------------------------------------------------------------
`default_nettype none

module sidac_dabble
   import sidac_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [VALUE_WIDTH-1:0] value,
   input  wire logic                   ack,
   output conv_result_type             result
);

   logic                   run_ff,  run_in;
   logic [CNT_WIDTH-1:0]   cnt_ff,  cnt_in;
   logic [VALUE_WIDTH-1:0] mag_ff,  mag_in;
   logic [BCD_WIDTH-1:0]   bcd_ff,  bcd_in;
   logic                   neg_ff,  neg_in;
   logic [BCD_WIDTH-1:0]   adj;

   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      run_in = run_ff;
      cnt_in = cnt_ff;
      mag_in = mag_ff;
      bcd_in = bcd_ff;
      neg_in = neg_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CNT_WIDTH'(VALUE_WIDTH);
         neg_in = value[VALUE_WIDTH-1];
         mag_in = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
         bcd_in = '0;
      end else if (run_ff && cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         bcd_in = {adj[BCD_WIDTH-2:0], mag_ff[VALUE_WIDTH-1]};
         mag_in = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
      end else if (ack) begin
         run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
      neg_ff <= neg_in;
   end

   assign result.done = run_ff && (cnt_ff == '0);
   assign result.neg  = neg_ff;
   assign result.bcd  = bcd_ff;

endmodule

`default_nettype wire

// ===== sv/sidac_emit.sv =====
// ----------------------------------------------------------------------------
// sidac_emit
// Character sequencer: sign, then digits from the leading nonzero one down,
// one per cycle into a registered output stage while it is free to take them.
// ----------------------------------------------------------------------------
`default_nettype none

module sidac_emit
   import sidac_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             load,
   input  conv_result_type       conv,
   output logic                  busy,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [7:0]            rsp_char_byte,
   output logic                  rsp_last_char
);

   logic [3:0]               dig_ff [NUM_DIGITS];
   logic [3:0]               dig_in [NUM_DIGITS];
   logic [DIG_IDX_WIDTH-1:0] idx_ff,   idx_in;
   logic                     sign_ff,  sign_in;
   logic                     act_ff,   act_in;
   logic                     vld_ff,   vld_in;
   logic [7:0]               char_ff,  char_in;
   logic                     last_ff,  last_in;
   logic [DIG_IDX_WIDTH-1:0] top_idx;
   logic                     take;

   always_comb begin
      top_idx = '0;
      for (int i = 1; i < NUM_DIGITS; i++) begin
         if (conv.bcd[4*i +: 4] != 4'd0) begin
            top_idx = DIG_IDX_WIDTH'(i);
         end
      end
   end

   assign take = !vld_ff || rsp_ready;

   always_comb begin
      dig_in  = dig_ff;
      idx_in  = idx_ff;
      sign_in = sign_ff;
      act_in  = act_ff;
      vld_in  = vld_ff;
      char_in = char_ff;
      last_in = last_ff;
      if (load) begin
         for (int i = 0; i < NUM_DIGITS; i++) begin
            dig_in[i] = conv.bcd[4*i +: 4];
         end
         idx_in  = top_idx;
         sign_in = conv.neg;
         act_in  = 1'b1;
         if (take) begin
            vld_in = 1'b0;
         end
      end else if (act_ff && take) begin
         vld_in = 1'b1;
         if (sign_ff) begin
            char_in = CHAR_MINUS;
            last_in = 1'b0;
            sign_in = 1'b0;
         end else begin
            char_in = CHAR_ZERO + {4'd0, dig_ff[idx_ff]};
            last_in = (idx_ff == '0);
            if (idx_ff == '0) begin
               act_in = 1'b0;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end
      end else if (take) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         vld_ff <= 1'b0;
      end else begin
         act_ff <= act_in;
         vld_ff <= vld_in;
      end
      dig_ff  <= dig_in;
      idx_ff  <= idx_in;
      sign_ff <= sign_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign busy          = act_ff;
   assign rsp_valid     = vld_ff;
   assign rsp_char_byte = char_ff;
   assign rsp_last_char = last_ff;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for signed_int_to_decimal_ascii_core. Signed values go in on
// req_; the ASCII text that comes back on rsp_ is checked byte by byte,
// including the end-of-number flag. A directed table covers the extremes,
// zero, the most negative value and the decade boundaries; random values
// follow. Both sides idle at random, the receiver holds off for a long
// stretch to back the block up, and the sender pauses twice until the block
// has drained.
// ----------------------------------------------------------------------------

module tb
   import sidac_pkg::*;
;

   localparam int NUM_ITEMS = 360;
   localparam int NUM_ROWS  = 20;

   typedef struct {
      logic [VALUE_WIDTH-1:0] value;
      string                  text;  // empty: use the predictor
   } dir_row_type;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       last_char;
   } ascii_char_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [VALUE_WIDTH-1:0] req_value;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [7:0]             rsp_char_byte;
   logic                   rsp_last_char;

   ascii_char_type text_due[$];
   bit             failed;

   dir_row_type dir_rows [NUM_ROWS] = '{
      '{32'd0,           "0"},
      '{32'd1,           "1"},
      '{-32'sd1,         "-1"},
      '{32'd9,           "9"},
      '{32'd10,          "10"},
      '{-32'sd10,        "-10"},
      '{32'd99,          "99"},
      '{32'd100,         "100"},
      '{32'h7FFFFFFF,    "2147483647"},
      '{32'h80000000,    "-2147483648"},
      '{32'h80000001,    "-2147483647"},
      '{32'd1000000000,  "1000000000"},
      '{32'd999999999,   "999999999"},
      '{-32'sd1000000000, "-1000000000"},
      '{32'h55555555,    ""},
      '{32'hAAAAAAAA,    ""},
      '{32'h0F0F0F0F,    ""},
      '{32'hF0F0F0F0,    ""},
      '{32'hFFFFFFF6,    ""},
      '{32'h7FFFFFFE,    ""}
   };

   signed_int_to_decimal_ascii_core uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_byte (rsp_char_byte),
      .rsp_last_char (rsp_last_char)
   );

   function automatic void queue_decimal_text(input logic [VALUE_WIDTH-1:0] v);
      logic [VALUE_WIDTH-1:0] mag;
      logic [7:0]             digs[$];
      logic                   neg;
      int                     i;
      neg = v[VALUE_WIDTH-1];
      mag = neg ? (~v + 1'b1) : v;
      do begin
         digs.push_front(CHAR_ZERO + 8'(mag % 10));
         mag = mag / 10;
      end while (mag != 0);
      if (neg)
         text_due.push_back('{CHAR_MINUS, 1'b0});
      for (i = 0; i < digs.size(); i++)
         text_due.push_back('{digs[i], i == digs.size() - 1});
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

   // sender
   initial begin : req_side
      logic [VALUE_WIDTH-1:0] v;
      logic [VALUE_WIDTH-1:0] mag;
      int unsigned            pick;
      int                     n;
      int                     k;
      string                  txt;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_value <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (n = 0; n < NUM_ITEMS; n++) begin
         txt = "";
         if (n < NUM_ROWS) begin
            v   = dir_rows[n].value;
            txt = dir_rows[n].text;
         end else begin
            pick = $urandom_range(99);
            if (pick < 40) begin
               v = $urandom;
            end else if (pick < 70) begin
               k   = $urandom_range(VALUE_WIDTH - 1, 1);
               mag = $urandom & ((32'd1 << k) - 1);
               v   = $urandom_range(1) ? -mag : mag;
            end else if (pick < 85) begin
               mag = 1;
               repeat ($urandom_range(9)) mag = mag * 10;
               mag = mag + $urandom_range(2) - 1;
               v   = $urandom_range(1) ? -mag : mag;
            end else begin
               mag = $urandom_range(20);
               v   = $urandom_range(1) ? -mag : mag;
            end
         end
         if (n == 100 || n == 260) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (text_due.size() != 0) @(posedge clock);
         end
         req_value <= v;
         req_valid <= 1'b1;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         if (txt.len() != 0) begin
            for (k = 0; k < txt.len(); k++)
               text_due.push_back('{txt[k], k == txt.len() - 1});
         end else begin
            queue_decimal_text(v);
         end
         if (!(n >= 150 && n < 220) && $urandom_range(99) < 24) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(40, 1)) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
      while (text_due.size() != 0) @(posedge clock);
      repeat (VALUE_WIDTH + 30) @(posedge clock);
      if (!failed) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // receiver
   initial begin : rsp_side
      int hold_left;
      int chars_taken;
      bit held;
      hold_left   = 0;
      chars_taken = 0;
      held        = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            chars_taken++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!held && chars_taken >= 300) begin
            held      = 1;
            hold_left = 400;
            rsp_ready <= 1'b0;
         end else if (chars_taken >= 1200 && chars_taken < 1800) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 24);
         end
      end
   end

   // checker
   initial begin : rsp_check
      ascii_char_type want;
      failed = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (text_due.size() == 0) begin
               $error("unexpected item: char_byte %0d, last_char %0d",
                      rsp_char_byte, rsp_last_char);
               failed = 1;
            end else begin
               want = text_due.pop_front();
               if (rsp_char_byte !== want.char_byte) begin
                  $error("char_byte: expected %0d, got %0d", want.char_byte, rsp_char_byte);
                  failed = 1;
               end
               if (rsp_last_char !== want.last_char) begin
                  $error("last_char: expected %0d, got %0d", want.last_char, rsp_last_char);
                  failed = 1;
               end
            end
         end
      end
   end

endmodule

// ===== sim.f =====
sv/sidac_pkg.sv
sv/sidac_dabble.sv
sv/sidac_emit.sv
sv/signed_int_to_decimal_ascii_core.sv
sim/tb.sv
